### rtl/adfe_pkg.sv
// Shared types and constants for the audio ducking fade envelope engine.
// No dependencies; every file but the interfaces and the checker imports this package.
package adfe_pkg;

  localparam int MAX_MOTIONS = 16;
  localparam int IDX_W       = $clog2(MAX_MOTIONS);
  localparam int CNT_W       = $clog2(MAX_MOTIONS + 1);
  localparam int LEV_W       = 24;
  localparam int DIV_STEPS   = 23;
  localparam int DCNT_W      = $clog2(DIV_STEPS);
  localparam logic [LEV_W-1:0] FULL_LEVEL = 24'd6553600;
  localparam logic [6:0] MAX_PERCENT = 7'd100;
  localparam logic signed [15:0] DELAY_REUSE = -16'sd1;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_CLAIM = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_DELAY_IN  = 3'd0,
    PH_FADE_DOWN = 3'd1,
    PH_HOLD      = 3'd2,
    PH_DELAY_OUT = 3'd3,
    PH_FADE_UP   = 3'd4,
    PH_REMOVE    = 3'd5
  } phase_t;

  typedef struct packed {
    cmd_t               command;
    logic [15:0]        voice_id;
    logic [31:0]        asset_id;
    logic               is_effect;
    logic               policy_found;
    logic signed [15:0] fade_in_delay;
    logic signed [15:0] fade_out_delay;
    logic [14:0]        fade_in_duration;
    logic [14:0]        fade_out_duration;
    logic [6:0]         target_percent;
    logic [15:0]        delta_t;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_entry_t;

  typedef struct packed {
    logic [15:0]        voice;
    phase_t             phase;
    logic [LEV_W-1:0]   level;
    logic signed [23:0] slope;
    logic [31:0]        elapsed;
    logic signed [15:0] wait_in;
    logic signed [15:0] wait_out;
    logic [14:0]        len_in;
    logic [14:0]        len_out;
    logic [6:0]         target;
  } slot_t;

endpackage

### rtl/adfe_if.sv
// Handshake interfaces for the command and result channels.
// Depends on nothing; payload widths follow the command and result fields.
interface adfe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] voice_id;
  logic [31:0] asset_id;
  logic        is_effect;
  logic        policy_found;
  logic signed [15:0] fade_in_delay;
  logic signed [15:0] fade_out_delay;
  logic [14:0] fade_in_duration;
  logic [14:0] fade_out_duration;
  logic [6:0]  target_percent;
  logic [15:0] delta_t;

  modport source (output valid, command, voice_id, asset_id, is_effect, policy_found,
                  fade_in_delay, fade_out_delay, fade_in_duration, fade_out_duration,
                  target_percent, delta_t, input ready);
  modport sink (input valid, command, voice_id, asset_id, is_effect, policy_found,
                fade_in_delay, fade_out_delay, fade_in_duration, fade_out_duration,
                target_percent, delta_t, output ready);
endinterface

interface adfe_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  volume_percent;
  logic        apply_volume;
  logic [31:0] active_asset;
  logic [4:0]  motion_count;

  modport source (output valid, volume_percent, apply_volume, active_asset, motion_count,
                  input ready);
  modport sink (input valid, volume_percent, apply_volume, active_asset, motion_count,
                output ready);
endinterface

### rtl/adfe_front.sv
// Front end: takes commands, saturates the target and resolves the fade-out delay.
// Depends on adfe_pkg and adfe_in_if.
module adfe_front (
  adfe_in_if.sink             in_ch,
  input  logic                q_full,
  output adfe_pkg::q_entry_t  push
);
  import adfe_pkg::*;

  always_comb begin
    in_ch.ready            = !q_full;
    push.valid             = in_ch.valid && !q_full;
    push.item.command      = cmd_t'(in_ch.command);
    push.item.voice_id     = in_ch.voice_id;
    push.item.asset_id     = in_ch.asset_id;
    push.item.is_effect    = in_ch.is_effect;
    push.item.policy_found = in_ch.policy_found;
    push.item.fade_in_delay  = in_ch.fade_in_delay;
    push.item.fade_out_delay = (in_ch.fade_out_delay == DELAY_REUSE) ?
                               in_ch.fade_in_delay : in_ch.fade_out_delay;
    push.item.fade_in_duration  = in_ch.fade_in_duration;
    push.item.fade_out_duration = in_ch.fade_out_duration;
    push.item.target_percent = (in_ch.target_percent > MAX_PERCENT) ?
                               MAX_PERCENT : in_ch.target_percent;
    push.item.delta_t = in_ch.delta_t;
  end

endmodule

### rtl/adfe_queue.sv
// Two-entry queue between the front end and the motion engine.
// Depends on adfe_pkg.
module adfe_queue (
  input  logic               clk,
  input  logic               rst,
  input  adfe_pkg::q_entry_t push,
  output logic               full,
  output adfe_pkg::q_entry_t head,
  input  logic               pop
);
  import adfe_pkg::*;

  item_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   fill;

  assign full       = (fill == (Q_PTR_W+1)'(Q_DEPTH));
  assign head.valid = (fill != '0);
  assign head.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid) begin
        mem[wr_ptr] <= push.item;
        wr_ptr      <= wr_ptr + 1'b1;
      end
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (Q_PTR_W+1)'(push.valid) - (Q_PTR_W+1)'(pop);
    end
  end

endmodule

### rtl/adfe_back.sv
// Motion engine: executes commands, walks the motion table on ticks, serial slope divider.
// Depends on adfe_pkg and adfe_out_if.
module adfe_back (
  input  logic               clk,
  input  logic               rst,
  input  adfe_pkg::q_entry_t head,
  output logic               pop,
  adfe_out_if.source         out_ch
);
  import adfe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_STOP, S_LOAD, S_DIV, S_MUL, S_ADD, S_WB, S_EMIT
  } state_t;

  state_t             state;
  item_t              cur;
  slot_t              slots [MAX_MOTIONS];
  slot_t              w;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   k;
  logic [IDX_W-1:0]   hit;
  logic               hit_ok;
  logic               act_valid;
  logic [31:0]        act_handle;
  logic [LEV_W-1:0]   minimum;
  logic [DIV_STEPS-1:0] dvd;
  logic [15:0]        rem;
  logic [DIV_STEPS-1:0] quot;
  logic [14:0]        divisor;
  logic [DCNT_W-1:0]  dcnt;
  logic               down;
  logic signed [40:0] prod;
  logic               o_valid;
  logic [6:0]         o_volume;
  logic               o_apply;
  logic [31:0]        o_asset;
  logic [4:0]         o_count;

  slot_t              rd;
  slot_t              ld;
  slot_t              wb;
  logic [LEV_W-1:0]   rd_tlev;
  logic [LEV_W-1:0]   w_tlev;
  logic               due_in;
  logic               due_out;
  logic [15:0]        trial;
  logic               qbit;
  logic [DIV_STEPS-1:0] qn;
  logic signed [41:0] sum;
  logic [32:0]        tsum;

  always_comb begin
    rd      = slots[idx];
    rd_tlev = {1'b0, rd.target, 16'b0};
    w_tlev  = {1'b0, w.target, 16'b0};
    due_in  = rd.wait_in[15] || (rd.elapsed >= {16'b0, rd.wait_in});
    due_out = rd.wait_out[15] || (rd.elapsed >= {16'b0, rd.wait_out});
    trial   = {rem[14:0], dvd[DIV_STEPS-1]};
    qbit    = (trial >= {1'b0, divisor});
    qn      = {quot[DIV_STEPS-2:0], qbit};
    sum     = $signed({18'b0, w.level}) + $signed({prod[40], prod});
    tsum    = {1'b0, w.elapsed} + {17'b0, cur.delta_t};
    pop     = (state == S_IDLE) && head.valid;
    // A zero-length fade completes at once, in the tick where its wait ends.
    ld      = rd;
    if (rd.phase == PH_DELAY_IN && due_in && rd.len_in == '0) begin
      ld.level = rd_tlev;
      ld.phase = PH_HOLD;
      ld.slope = '0;
    end
    if (rd.phase == PH_DELAY_OUT && due_out && rd.len_out == '0) begin
      ld.level = FULL_LEVEL;
      ld.phase = PH_REMOVE;
      ld.slope = '0;
    end
    wb         = w;
    wb.elapsed = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
  end

  assign out_ch.valid          = o_valid;
  assign out_ch.volume_percent = o_volume;
  assign out_ch.apply_volume   = o_apply;
  assign out_ch.active_asset   = o_asset;
  assign out_ch.motion_count   = o_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      act_valid  <= 1'b0;
      act_handle <= '0;
      o_valid    <= 1'b0;
    end else begin
      if (o_valid && out_ch.ready && state != S_EMIT) o_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            cur <= head.item;
            unique case (head.item.command)
              CMD_START: begin
                if (!head.item.is_effect) begin
                  act_valid  <= 1'b1;
                  act_handle <= head.item.asset_id;
                end
                if (head.item.policy_found && count < CNT_W'(MAX_MOTIONS)) begin
                  slots[count[IDX_W-1:0]] <= '{voice: head.item.voice_id,
                    phase: PH_DELAY_IN, level: FULL_LEVEL, slope: '0, elapsed: '0,
                    wait_in: head.item.fade_in_delay, wait_out: head.item.fade_out_delay,
                    len_in: head.item.fade_in_duration,
                    len_out: head.item.fade_out_duration,
                    target: head.item.target_percent};
                  count <= count + 1'b1;
                end
              end
              CMD_STOP: begin
                if (act_valid && head.item.asset_id == act_handle) begin
                  act_valid  <= 1'b0;
                  act_handle <= '0;
                end
                k      <= '0;
                hit_ok <= 1'b0;
                state  <= S_STOP;
              end
              CMD_CLAIM: begin
                if (!head.item.is_effect && !act_valid) begin
                  act_valid  <= 1'b1;
                  act_handle <= head.item.asset_id;
                end
              end
              CMD_TICK: begin
                minimum <= FULL_LEVEL;
                if (count == '0) begin
                  state <= S_EMIT;
                end else begin
                  idx   <= IDX_W'(count - 1'b1);
                  state <= S_LOAD;
                end
              end
              default: ;
            endcase
          end
        end
        S_STOP: begin
          if (k == count) begin
            if (hit_ok) begin
              slots[hit].elapsed <= '0;
              slots[hit].phase   <= PH_DELAY_OUT;
            end
            state <= S_IDLE;
          end else begin
            if (slots[k[IDX_W-1:0]].voice == cur.voice_id) begin
              hit    <= k[IDX_W-1:0];
              hit_ok <= 1'b1;
            end
            k <= k + 1'b1;
          end
        end
        S_LOAD: begin
          w     <= ld;
          state <= S_WB;
          case (rd.phase) inside
            PH_DELAY_IN: begin
              if (due_in && rd.len_in != '0) begin
                dvd     <= DIV_STEPS'(FULL_LEVEL - rd_tlev);
                divisor <= rd.len_in;
                rem     <= '0;
                dcnt    <= '0;
                down    <= 1'b1;
                state   <= S_DIV;
              end
            end
            PH_DELAY_OUT: begin
              if (due_out && rd.len_out != '0) begin
                dvd     <= DIV_STEPS'(FULL_LEVEL - rd_tlev);
                divisor <= rd.len_out;
                rem     <= '0;
                dcnt    <= '0;
                down    <= 1'b0;
                state   <= S_DIV;
              end
            end
            PH_FADE_DOWN, PH_FADE_UP: state <= S_MUL;
            PH_REMOVE: begin
              // Close the gap; entries below idx are untouched, so the walk goes on.
              for (int j = 0; j < MAX_MOTIONS - 1; j++) begin
                if (IDX_W'(j) >= idx && CNT_W'(j + 1) < count) slots[j] <= slots[j + 1];
              end
              count <= count - 1'b1;
              if (idx == '0) begin
                state <= S_EMIT;
              end else begin
                idx   <= idx - 1'b1;
                state <= S_LOAD;
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          rem  <= qbit ? (trial - {1'b0, divisor}) : trial;
          quot <= qn;
          dvd  <= dvd << 1;
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_W'(DIV_STEPS - 1)) begin
            w.slope <= down ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
            w.phase <= down ? PH_FADE_DOWN : PH_FADE_UP;
            state   <= S_WB;
          end
        end
        S_MUL: begin
          prod  <= w.slope * $signed({1'b0, cur.delta_t});
          state <= S_ADD;
        end
        S_ADD: begin
          if (w.phase == PH_FADE_DOWN) begin
            if (sum <= $signed({18'b0, w_tlev})) begin
              w.level <= w_tlev;
              w.phase <= PH_HOLD;
              w.slope <= '0;
            end else begin
              w.level <= sum[LEV_W-1:0];
            end
          end else begin
            if (sum >= $signed({18'b0, FULL_LEVEL})) begin
              w.level <= FULL_LEVEL;
              w.phase <= PH_REMOVE;
              w.slope <= '0;
            end else begin
              w.level <= sum[LEV_W-1:0];
            end
          end
          state <= S_WB;
        end
        S_WB: begin
          if (w.level < minimum) minimum <= w.level;
          slots[idx] <= wb;
          if (idx == '0) begin
            state <= S_EMIT;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_LOAD;
          end
        end
        S_EMIT: begin
          if (!o_valid || out_ch.ready) begin
            o_valid  <= 1'b1;
            o_volume <= minimum[22:16];
            o_apply  <= act_valid;
            o_asset  <= act_valid ? act_handle : '0;
            o_count  <= 5'(count);
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/audio_ducking_fade_envelope_engine.sv
// Audio ducking fade envelope engine, top level.
// Items pass through the queue; start and claim are then done in the idle state and
// a stop scans the table entry by entry. A tick walks the table newest motion first,
// dropping removed motions, updating the rest and computing a slope when a fade begins
// (23-step serial slope divider); a stalled result holds the engine. Items are handled
// one at a time. Reset is synchronous and clears queue, table count, asset and valid.
module audio_ducking_fade_envelope_engine (
  input  logic       clk,
  input  logic       rst,
  adfe_in_if.sink    in_ch,
  adfe_out_if.source out_ch
);
  import adfe_pkg::*;

  q_entry_t push;
  q_entry_t head;
  logic     q_full;
  logic     pop;

  // The front end saturates the target and resolves the fade-out delay before an item enters the queue.
  adfe_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  // Queue decouples command intake from the motion engine.
  adfe_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  // The engine holds the motion table and registers each tick's result.
  adfe_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

### rtl/adfe_checker.sv
// Port-level checks on the result channel, bound to the top level.
// Depends on the top level's ports only.
module adfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        o_valid,
  input logic        o_ready,
  input logic [6:0]  volume_percent,
  input logic        apply_volume,
  input logic [31:0] active_asset,
  input logic [4:0]  motion_count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_ready |=> o_valid && $stable(volume_percent) && $stable(active_asset))
    else $error("result changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> motion_count <= 5'd16)
    else $error("motion count above table size");

  a_volume: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> volume_percent <= 7'd100)
    else $error("volume above full");

  a_asset: assert property (@(posedge clk) disable iff (rst)
    o_valid && !apply_volume |-> active_asset == 32'd0)
    else $error("asset shown without an active asset");

endmodule

bind audio_ducking_fade_envelope_engine adfe_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .o_valid        (out_ch.valid),
  .o_ready        (out_ch.ready),
  .volume_percent (out_ch.volume_percent),
  .apply_volume   (out_ch.apply_volume),
  .active_asset   (out_ch.active_asset),
  .motion_count   (out_ch.motion_count)
);

### test/adfe_tb_pkg.sv
// Testbench-side package: holds the result record that the predictor queues.
// Depends on adfe_pkg; kept minimal so the testbench compiles in one pass.
package adfe_tb_pkg;
  import adfe_pkg::*;
  typedef struct packed {
    logic [6:0]  volume_percent;
    logic        apply_volume;
    logic [31:0] active_asset;
    logic [4:0]  motion_count;
  } duck_result_t;
endpackage

### test/testbench.sv
// Testbench for the audio ducking fade envelope engine: directed and random
// command streams checked against an in-bench envelope predictor.
// Depends on adfe_pkg, adfe_tb_pkg and the adfe_in_if / adfe_out_if interfaces.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import adfe_pkg::*;
  import adfe_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  adfe_in_if in_ch ();
  adfe_out_if out_ch ();

  audio_ducking_fade_envelope_engine uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: one entry per live motion, newest at the highest index.
  logic [15:0]        mot_voice [MAX_MOTIONS];
  logic [2:0]         mot_phase [MAX_MOTIONS];
  longint             mot_level [MAX_MOTIONS];
  longint             mot_slope [MAX_MOTIONS];
  longint unsigned    mot_time  [MAX_MOTIONS];
  logic signed [15:0] mot_win   [MAX_MOTIONS];
  logic signed [15:0] mot_wout  [MAX_MOTIONS];
  logic [14:0]        mot_lin   [MAX_MOTIONS];
  logic [14:0]        mot_lout  [MAX_MOTIONS];
  logic [6:0]         mot_tgt   [MAX_MOTIONS];
  int                 live_motions;
  logic               asset_held;
  logic [31:0]        held_asset;

  duck_result_t expected_volumes[$];
  int  failures = 0;
  int  idle_pct = 31;   // sender and receiver idle percentage; 0 for a calm stretch
  int  quiet_cycles = 0;
  logic [15:0] voice_pool[4] = '{16'h0001, 16'h0002, 16'hFFFF, 16'h0000};

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    failures++;
  endtask

  // Removes one motion and shifts the newer ones down, as the engine's table does.
  function automatic void retire_motion(input int idx);
    for (int j = idx; j < live_motions - 1; j++) begin
      mot_voice[j] = mot_voice[j+1]; mot_phase[j] = mot_phase[j+1];
      mot_level[j] = mot_level[j+1]; mot_slope[j] = mot_slope[j+1];
      mot_time[j]  = mot_time[j+1];  mot_win[j]   = mot_win[j+1];
      mot_wout[j]  = mot_wout[j+1];  mot_lin[j]   = mot_lin[j+1];
      mot_lout[j]  = mot_lout[j+1];  mot_tgt[j]   = mot_tgt[j+1];
    end
    live_motions--;
  endfunction

  // Applies one accepted item to the predictor; a tick queues its report.
  function automatic void predict_envelope(input item_t it);
    logic [6:0] tgt;
    longint     lowest, tlev;
    int         hit;
    duck_result_t r;
    lowest = FULL_LEVEL;
    tgt = (it.target_percent > MAX_PERCENT) ? MAX_PERCENT : it.target_percent;
    case (it.command)
      CMD_START: begin
        if (!it.is_effect) begin
          asset_held = 1'b1; held_asset = it.asset_id;
        end
        if (it.policy_found && live_motions < MAX_MOTIONS) begin
          mot_voice[live_motions] = it.voice_id;
          mot_phase[live_motions] = PH_DELAY_IN;
          mot_level[live_motions] = FULL_LEVEL;
          mot_slope[live_motions] = 0;
          mot_time[live_motions]  = 0;
          mot_win[live_motions]   = it.fade_in_delay;
          // A fade-out delay of minus one means "same as the fade-in delay".
          mot_wout[live_motions]  = (it.fade_out_delay == DELAY_REUSE) ?
                                    it.fade_in_delay : it.fade_out_delay;
          mot_lin[live_motions]   = it.fade_in_duration;
          mot_lout[live_motions]  = it.fade_out_duration;
          mot_tgt[live_motions]   = tgt;
          live_motions++;
        end
      end
      CMD_STOP: begin
        if (asset_held && it.asset_id == held_asset) begin
          asset_held = 1'b0; held_asset = '0;
        end
        hit = -1;
        for (int k = 0; k < live_motions; k++)
          if (mot_voice[k] == it.voice_id) hit = k;
        if (hit >= 0) begin
          mot_time[hit] = 0; mot_phase[hit] = PH_DELAY_OUT;
        end
      end
      CMD_CLAIM: begin
        if (!it.is_effect && !asset_held) begin
          asset_held = 1'b1; held_asset = it.asset_id;
        end
      end
      default: begin
        for (int i = live_motions - 1; i >= 0; i--) begin
          // A motion that reached the remove phase on an earlier tick is dropped
          // now, without counting or aging; one that reaches it this tick counts once.
          if (mot_phase[i] == PH_REMOVE) begin
            retire_motion(i);
            continue;
          end
          tlev = longint'(mot_tgt[i]) << 16;
          case (mot_phase[i])
            PH_DELAY_IN: if (longint'(mot_time[i]) >= longint'(mot_win[i])) begin
              if (mot_lin[i] == 0) begin
                mot_level[i] = tlev; mot_phase[i] = PH_HOLD; mot_slope[i] = 0;
              end else begin
                mot_slope[i] = -((FULL_LEVEL - tlev) / mot_lin[i]);
                mot_phase[i] = PH_FADE_DOWN;
              end
            end
            PH_FADE_DOWN: begin
              mot_level[i] += mot_slope[i] * it.delta_t;
              if (mot_level[i] <= tlev) begin
                mot_level[i] = tlev; mot_phase[i] = PH_HOLD; mot_slope[i] = 0;
              end
            end
            PH_DELAY_OUT: if (longint'(mot_time[i]) >= longint'(mot_wout[i])) begin
              if (mot_lout[i] == 0) begin
                mot_level[i] = FULL_LEVEL; mot_phase[i] = PH_REMOVE; mot_slope[i] = 0;
              end else begin
                mot_slope[i] = (FULL_LEVEL - tlev) / mot_lout[i];
                mot_phase[i] = PH_FADE_UP;
              end
            end
            PH_FADE_UP: begin
              mot_level[i] += mot_slope[i] * it.delta_t;
              if (mot_level[i] >= FULL_LEVEL) begin
                mot_level[i] = FULL_LEVEL; mot_phase[i] = PH_REMOVE; mot_slope[i] = 0;
              end
            end
            default: ;
          endcase
          if (mot_level[i] < lowest) lowest = mot_level[i];
          mot_time[i] = (mot_time[i] + it.delta_t > 64'hFFFF_FFFF) ?
                        64'hFFFF_FFFF : mot_time[i] + it.delta_t;
        end
        r.volume_percent = 7'(lowest >> 16);
        r.apply_volume   = asset_held;
        r.active_asset   = asset_held ? held_asset : '0;
        r.motion_count   = 5'(live_motions);
        expected_volumes.push_back(r);
      end
    endcase
  endfunction

  // Sends one item, with random idle cycles before it; valid stays up for the next one.
  task automatic send_item(input item_t it);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= it.command;           in_ch.voice_id <= it.voice_id;
    in_ch.asset_id <= it.asset_id;         in_ch.is_effect <= it.is_effect;
    in_ch.policy_found <= it.policy_found; in_ch.fade_in_delay <= it.fade_in_delay;
    in_ch.fade_out_delay <= it.fade_out_delay;
    in_ch.fade_in_duration <= it.fade_in_duration;
    in_ch.fade_out_duration <= it.fade_out_duration;
    in_ch.target_percent <= it.target_percent;
    in_ch.delta_t <= it.delta_t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_envelope(it);
  endtask

  function automatic item_t random_item(input cmd_t c);
    item_t it;
    it = '0;
    it.command = c;
    it.voice_id = ($urandom_range(9, 0) == 0) ? 16'($urandom) : voice_pool[$urandom_range(3, 0)];
    it.asset_id = ($urandom_range(3, 0) == 0) ? $urandom : 32'($urandom_range(3, 0));
    it.is_effect = ($urandom_range(3, 0) == 0);
    it.policy_found = ($urandom_range(7, 0) != 0);
    case ($urandom_range(5, 0))
      0: it.fade_in_delay = 16'($urandom);
      1: it.fade_in_delay = -16'sd1;
      default: it.fade_in_delay = 16'($urandom_range(40, 0));
    endcase
    case ($urandom_range(5, 0))
      0: it.fade_out_delay = 16'($urandom);
      1: it.fade_out_delay = DELAY_REUSE;
      default: it.fade_out_delay = 16'($urandom_range(40, 0));
    endcase
    it.fade_in_duration  = ($urandom_range(5, 0) == 0) ? 15'($urandom) : 15'($urandom_range(30, 0));
    it.fade_out_duration = ($urandom_range(5, 0) == 0) ? 15'($urandom) : 15'($urandom_range(30, 0));
    it.target_percent = ($urandom_range(9, 0) == 0) ? 7'($urandom) : 7'($urandom_range(100, 0));
    it.delta_t = ($urandom_range(9, 0) == 0) ? 16'($urandom) : 16'($urandom_range(12, 0));
    return it;
  endfunction

  task automatic send_random(input int count);
    cmd_t c;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9, 0)) inside
        0, 1, 2: c = CMD_START;
        3, 4:    c = CMD_STOP;
        5:       c = CMD_CLAIM;
        default: c = CMD_TICK;
      endcase
      send_item(random_item(c));
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_volumes.size() != 0) @(posedge clk);
  endtask

  // Extremes of every field, each command, and the named corner cases.
  task automatic test_directed();
    item_t it;
    it = '0; it.command = CMD_TICK; send_item(it);           // empty table reads 100
    it = '0; it.command = CMD_START; it.policy_found = 1'b1; it.asset_id = 32'hFFFF_FFFF;
    it.voice_id = 16'hFFFF; it.target_percent = 7'h7F;       // saturates to 100
    it.fade_in_delay = 16'sh7FFF; it.fade_out_delay = -16'sh8000;
    it.fade_in_duration = 15'h7FFF; it.fade_out_duration = 15'h7FFF; send_item(it);
    it = '0; it.command = CMD_START; it.policy_found = 1'b1; it.voice_id = 16'h1;
    it.fade_in_delay = -16'sd5; it.fade_out_delay = DELAY_REUSE; send_item(it); // zero durations
    it = '0; it.command = CMD_START; it.is_effect = 1'b1; it.asset_id = 32'h55; send_item(it);
    it = '0; it.command = CMD_TICK; it.delta_t = 16'hFFFF; send_item(it);
    it = '0; it.command = CMD_STOP; it.voice_id = 16'h1; it.asset_id = 32'hFFFF_FFFF;
    send_item(it);
    it = '0; it.command = CMD_STOP; it.voice_id = 16'h1234; send_item(it); // no such voice
    it = '0; it.command = CMD_CLAIM; it.asset_id = 32'hA5A5_5A5A; send_item(it);
    it = '0; it.command = CMD_CLAIM; it.is_effect = 1'b1; it.asset_id = 32'h7; send_item(it);
    for (int k = 0; k < 3; k++) begin
      it = '0; it.command = CMD_TICK; it.delta_t = 16'hFFFF; send_item(it);
    end
    // Fill past the table size: the extra starts add no motion.
    for (int k = 0; k < MAX_MOTIONS + 2; k++) begin
      it = random_item(CMD_START); it.policy_found = 1'b1; it.fade_in_delay = '0;
      send_item(it);
    end
    it = '0; it.command = CMD_TICK; it.delta_t = 16'd3; send_item(it);
  endtask

  // Random commands, mostly on a pool of four voices, with some random voices mixed in.
  task automatic test_random_traffic();
    send_random(600);
    idle_pct = 0;                 // a calm stretch with back-to-back traffic
    send_random(200);
    idle_pct = 31;
  endtask

  task automatic test_drain_then_resume();
    drain_results();              // sender holds off until every report is in
    send_random(400);
  endtask

  always @(posedge clk) begin
    if (!rst) out_ch.ready <= ($urandom_range(99, 0) >= idle_pct);
  end

  // Result checker and idle watchdog.
  always @(posedge clk) begin
    duck_result_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("testbench failed");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_volumes.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_volumes.pop_front();
          if (out_ch.volume_percent != want.volume_percent)
            report_mismatch("volume_percent", out_ch.volume_percent, want.volume_percent);
          if (out_ch.apply_volume != want.apply_volume)
            report_mismatch("apply_volume", out_ch.apply_volume, want.apply_volume);
          if (out_ch.active_asset != want.active_asset)
            report_mismatch("active_asset", out_ch.active_asset, want.active_asset);
          if (out_ch.motion_count != want.motion_count)
            report_mismatch("motion_count", out_ch.motion_count, want.motion_count);
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.command = CMD_TICK; in_ch.voice_id = '0;
    in_ch.asset_id = '0; in_ch.is_effect = 1'b0; in_ch.policy_found = 1'b0;
    in_ch.fade_in_delay = '0; in_ch.fade_out_delay = '0; in_ch.fade_in_duration = '0;
    in_ch.fade_out_duration = '0; in_ch.target_percent = '0; in_ch.delta_t = '0;
    out_ch.ready = 1'b0;
    live_motions = 0; asset_held = 1'b0; held_asset = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_traffic();
    test_drain_then_resume();
    drain_results();
    repeat (1000) @(posedge clk);
    if (failures == 0 && expected_volumes.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

### audio_ducking_fade_envelope_engine.f
rtl/adfe_pkg.sv
rtl/adfe_if.sv
rtl/adfe_front.sv
rtl/adfe_queue.sv
rtl/adfe_back.sv
rtl/audio_ducking_fade_envelope_engine.sv
rtl/adfe_checker.sv
test/adfe_tb_pkg.sv
test/testbench.sv
